@@ rtl/core/i2p_pkg.sv @@
// Shared types, constants and character helpers for the infix to postfix converter.
package i2p_pkg;

    // Default operator stack depth.
    localparam int DEFAULT_STACK_DEPTH = 16;

    // Characters with a special meaning.
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_CARET  = 8'h5E;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Error codes carried on every result of an item.
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_FULL      = 2'd1;
    localparam logic [1:0] ERR_UNMATCHED = 2'd2;

    // How the converter treats an input character.
    typedef enum logic [1:0] {
        CLS_OPERAND,
        CLS_LPAREN,
        CLS_RPAREN,
        CLS_OPER
    } char_class_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic ready;     // controller can take a new item
        logic load;      // capture the input item
        logic emit_in;   // emit the stored character
        logic pop;       // pop the top of the stack
        logic pop_emit;  // the popped character is emitted
        logic push;      // push the stored character
        logic finish;    // close the item with its final result
    } i2p_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        char_class_t cls;
        logic        count_zero;
        logic        top_is_lparen;
        logic        top_ge;
        logic        last;
        logic        pend_valid;
        logic        out_free;
    } i2p_stat_t;

    // Operator priority; every other character is priority zero.
    function automatic logic [1:0] char_prio(input logic [7:0] c);
        logic [1:0] p;
        p = 2'd0;
        if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
        if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
        if (c == CH_CARET) p = 2'd3;
        return p;
    endfunction

    // Letters and digits are operands; parentheses are special; all else is an operator.
    function automatic char_class_t char_class(input logic [7:0] c);
        char_class_t k;
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h30 && c <= 8'h39))
            k = CLS_OPERAND;
        else if (c == CH_LPAREN)
            k = CLS_LPAREN;
        else if (c == CH_RPAREN)
            k = CLS_RPAREN;
        else
            k = CLS_OPER;
        return k;
    endfunction

endpackage

@@ rtl/core/infix_to_postfix_converter_top.sv @@
// Infix to postfix converter: one character per transfer, postfix characters out.
// Each item passes through the controller's work, flush and finish states, popping and emitting stack entries
// as needed; the final result of the item then leaves through the output register.
// One item at a time: the input stays stalled until the final result of the previous item has been issued,
// and an output stall holds it longer.
// Reset (rst_n low, asynchronous) empties the operator stack and drops any result in flight.
module infix_to_postfix_converter_top
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_char,
    input  logic       is_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       end_of_run,
    output logic       end_of_expression,
    output logic [1:0] error_code
);

    i2p_cmd_t  cmd;
    i2p_stat_t stat;

    assign in_stall = !cmd.ready;

    // Sequencer.
    i2p_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Stack and result path.
    i2p_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_char           (in_char),
        .is_last           (is_last),
        .cmd               (cmd),
        .stat              (stat),
        .out_stall         (out_stall),
        .out_valid         (out_valid),
        .out_char          (out_char),
        .has_char          (has_char),
        .end_of_run        (end_of_run),
        .end_of_expression (end_of_expression),
        .error_code        (error_code)
    );

    // An accepted item keeps the input stalled until its results are done.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after a transfer");

    // The controller never pops an empty stack.
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> !stat.count_zero)
        else $error("pop from an empty stack");

    // The end of an expression always closes a run.
    a_eoe_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_expression |-> end_of_run)
        else $error("end of expression without end of run");

    // A result without a character carries a zero character and ends its run.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_char |-> (out_char == CH_NUL) && end_of_run)
        else $error("malformed empty result");

endmodule

@@ rtl/core/i2p_ctrl.sv @@
// Controller state machine that sequences pops, pushes and results for one item.
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  i2p_stat_t stat,
    output i2p_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WORK,
        S_FLUSH,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   can_emit;

    // A new character may go to the pending slot once the slot can drain.
    assign can_emit = !stat.pend_valid || stat.out_free;

    // Command decode and next state.
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.load  = in_valid;
                if (in_valid) state_next = S_WORK;
            end
            S_WORK:
            begin
                unique case (stat.cls)
                    CLS_OPERAND:
                    begin
                        if (can_emit)
                        begin
                            cmd.emit_in = 1'b1;
                            state_next  = S_FLUSH;
                        end
                    end
                    CLS_LPAREN:
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_FLUSH;
                    end
                    CLS_RPAREN:
                    begin
                        if (!stat.count_zero && !stat.top_is_lparen)
                        begin
                            if (can_emit)
                            begin
                                cmd.pop      = 1'b1;
                                cmd.pop_emit = 1'b1;
                            end
                        end
                        else
                        begin
                            // Discard the matching opening parenthesis, if any.
                            cmd.pop    = !stat.count_zero;
                            state_next = S_FLUSH;
                        end
                    end
                    CLS_OPER:
                    begin
                        if (!stat.count_zero && stat.top_ge)
                        begin
                            if (can_emit)
                            begin
                                cmd.pop      = 1'b1;
                                cmd.pop_emit = 1'b1;
                            end
                        end
                        else
                        begin
                            cmd.push   = 1'b1;
                            state_next = S_FLUSH;
                        end
                    end
                    default: state_next = S_FLUSH;
                endcase
            end
            S_FLUSH:
            begin
                if (stat.last && !stat.count_zero)
                begin
                    if (can_emit)
                    begin
                        cmd.pop      = 1'b1;
                        cmd.pop_emit = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/core/i2p_datapath.sv @@
// Datapath: operator stack memory, top cache, pending result and output register.
module i2p_datapath
    import i2p_pkg::*;
#(
    parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] in_char,
    input  logic       is_last,
    input  i2p_cmd_t   cmd,
    output i2p_stat_t  stat,
    input  logic       out_stall,
    output logic       out_valid,
    output logic [7:0] out_char,
    output logic       has_char,
    output logic       end_of_run,
    output logic       end_of_expression,
    output logic [1:0] error_code
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STACK_DEPTH);

    logic [7:0]    mem [STACK_DEPTH];
    logic [7:0]    char_reg;
    logic          last_reg;
    logic [1:0]    err_reg;
    logic [1:0]    err_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] open_reg;
    logic [7:0]    top_reg;
    logic [7:0]    below_reg;
    logic          pend_valid_reg;
    logic [7:0]    pend_char_reg;
    logic          out_valid_reg;
    logic          full;
    logic          push_ok;
    logic          emit;
    logic [7:0]    emit_char;
    logic          move_out;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [CW-1:0] rd_count;

    assign full      = (count_reg == FULL_COUNT);
    assign push_ok   = cmd.push && !full;
    assign wr_addr   = count_reg[AW-1:0];
    assign rd_count  = count_reg - CW'(3);
    assign rd_addr   = rd_count[AW-1:0];
    assign emit      = cmd.emit_in || (cmd.pop && cmd.pop_emit);
    assign emit_char = cmd.emit_in ? char_reg : top_reg;
    assign move_out  = (emit && pend_valid_reg) || cmd.finish;

    // Error of an item is known when it is taken: the stack and the open count decide it.
    always_comb
    begin
        err_next = ERR_NONE;
        unique case (char_class(in_char))
            CLS_LPAREN:
                if (full) err_next = ERR_FULL;
            CLS_RPAREN:
                if (open_reg == '0) err_next = ERR_UNMATCHED;
            CLS_OPER:
                if (full && (char_prio(top_reg) < char_prio(in_char))) err_next = ERR_FULL;
            default:
                err_next = ERR_NONE;
        endcase
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= in_char;
            last_reg <= is_last;
            err_reg  <= err_next;
        end
    end

    // Stack memory write and next-below read; the top two entries are cached.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_addr] <= char_reg;
            top_reg      <= char_reg;
            below_reg    <= top_reg;
        end
        else if (cmd.pop)
        begin
            top_reg   <= below_reg;
            below_reg <= mem[rd_addr];
        end
    end

    // Stack depth and count of stacked opening parentheses.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            open_reg  <= '0;
        end
        else if (push_ok)
        begin
            count_reg <= count_reg + CW'(1);
            if (char_reg == CH_LPAREN) open_reg <= open_reg + CW'(1);
        end
        else if (cmd.pop)
        begin
            count_reg <= count_reg - CW'(1);
            if (top_reg == CH_LPAREN) open_reg <= open_reg - CW'(1);
        end
    end

    // Pending slot holds the newest character until it is known whether it is the last one.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_valid_reg <= 1'b0;
        else if (emit)
            pend_valid_reg <= 1'b1;
        else if (cmd.finish)
            pend_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit) pend_char_reg <= emit_char;
    end

    // Output register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (move_out)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (move_out)
        begin
            out_char          <= pend_valid_reg ? pend_char_reg : CH_NUL;
            has_char          <= pend_valid_reg;
            end_of_run        <= cmd.finish;
            end_of_expression <= cmd.finish && last_reg;
            error_code        <= err_reg;
        end
    end

    assign out_valid = out_valid_reg;

    // Status toward the controller.
    always_comb
    begin
        stat.cls           = char_class(char_reg);
        stat.count_zero    = (count_reg == '0);
        stat.top_is_lparen = (top_reg == CH_LPAREN);
        stat.top_ge        = (char_prio(top_reg) >= char_prio(char_reg));
        stat.last          = last_reg;
        stat.pend_valid    = pend_valid_reg;
        stat.out_free      = !out_valid_reg || !out_stall;
    end

endmodule
